@@ hw/rtl/gwff_pkg.sv @@
`timescale 1ns / 1ps

package gwff_pkg;

  // Request function codes
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_RUN  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // Cell states held in the map
  localparam logic [1:0] ST_UNKNOWN  = 2'd0;
  localparam logic [1:0] ST_FREE     = 2'd1;
  localparam logic [1:0] ST_OCCUPIED = 2'd2;
  localparam logic [1:0] ST_FRONTIER = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_GRID_SIDE = 2'd0;
  localparam logic [1:0] CFG_SEED_COL  = 2'd1;
  localparam logic [1:0] CFG_SEED_ROW  = 2'd2;

  localparam int CFG_DATA_W = 7;

  // Reset values of the configuration registers
  localparam logic [6:0] GRID_SIDE_RST = 7'd64;
  localparam logic [5:0] SEED_COL_RST  = 6'd32;
  localparam logic [5:0] SEED_ROW_RST  = 6'd32;

  // Datapath operations issued by the controller
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_CLR_START = 4'd1;
  localparam logic [3:0] OP_CLR_STEP  = 4'd2;
  localparam logic [3:0] OP_LOAD      = 4'd3;
  localparam logic [3:0] OP_READ      = 4'd4;
  localparam logic [3:0] OP_SEED      = 4'd5;
  localparam logic [3:0] OP_POP       = 4'd6;
  localparam logic [3:0] OP_MARK      = 4'd7;
  localparam logic [3:0] OP_NRD       = 4'd8;
  localparam logic [3:0] OP_NDEC      = 4'd9;
  localparam logic [3:0] OP_CAP_RUN   = 4'd10;
  localparam logic [3:0] OP_CAP_READ  = 4'd11;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic q_empty;
    logic nbr_last;
    logic seed_out;
  } stat_t;

endpackage

@@ hw/rtl/gwff_if.sv @@
`timescale 1ns / 1ps

// Request channel
interface gwff_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [11:0] cell_index;
  logic        obstacle;

  modport source (output valid, output func, output cell_index, output obstacle,
                  input ready);
  modport sink   (input valid, input func, input cell_index, input obstacle,
                  output ready);
endinterface

// Reply channel
interface gwff_out_if;
  logic       valid;
  logic       ready;
  logic       reply_kind;
  logic [1:0] cell_state;
  logic       run_status;

  modport source (output valid, output reply_kind, output cell_state,
                  output run_status, input ready);
  modport sink   (input valid, input reply_kind, input cell_state,
                  input run_status, output ready);
endinterface

@@ hw/rtl/gwff_ctrl.sv @@
`timescale 1ns / 1ps

module gwff_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     in_func_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  gwff_pkg::stat_t stat_i,
  output gwff_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_SEEDCHK = 4'd2;
  localparam logic [3:0] S_NEXT    = 4'd3;
  localparam logic [3:0] S_MARK    = 4'd4;
  localparam logic [3:0] S_NRD     = 4'd5;
  localparam logic [3:0] S_NDEC    = 4'd6;
  localparam logic [3:0] S_RDCAP   = 4'd7;
  localparam logic [3:0] S_RESP    = 4'd8;

  logic [3:0] state_q, state_d;
  logic       run_pend_q, run_pend_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);

  // Next state and operation select
  always_comb begin
    state_d    = state_q;
    run_pend_d = run_pend_q;
    cmd_o.op   = gwff_pkg::OP_NONE;
    case (state_q)
      S_CLR: begin
        cmd_o.op = gwff_pkg::OP_CLR_STEP;
        if (stat_i.clr_done) begin
          state_d = run_pend_q ? S_SEEDCHK : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_func_i)
            gwff_pkg::FUNC_LOAD: cmd_o.op = gwff_pkg::OP_LOAD;
            gwff_pkg::FUNC_RUN: begin
              cmd_o.op   = gwff_pkg::OP_CLR_START;
              run_pend_d = 1'b1;
              state_d    = S_CLR;
            end
            gwff_pkg::FUNC_READ: begin
              cmd_o.op = gwff_pkg::OP_READ;
              state_d  = S_RDCAP;
            end
            default: cmd_o.op = gwff_pkg::OP_NONE;
          endcase
        end
      end
      S_SEEDCHK: begin
        run_pend_d = 1'b0;
        if (stat_i.seed_out) begin
          cmd_o.op = gwff_pkg::OP_CAP_RUN;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = gwff_pkg::OP_SEED;
          state_d  = S_NEXT;
        end
      end
      S_NEXT: begin
        if (stat_i.q_empty) begin
          cmd_o.op = gwff_pkg::OP_CAP_RUN;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = gwff_pkg::OP_POP;
          state_d  = S_MARK;
        end
      end
      S_MARK: begin
        cmd_o.op = gwff_pkg::OP_MARK;
        state_d  = S_NRD;
      end
      S_NRD: begin
        cmd_o.op = gwff_pkg::OP_NRD;
        state_d  = S_NDEC;
      end
      S_NDEC: begin
        cmd_o.op = gwff_pkg::OP_NDEC;
        state_d  = stat_i.nbr_last ? S_NEXT : S_NRD;
      end
      S_RDCAP: begin
        cmd_o.op = gwff_pkg::OP_CAP_READ;
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      run_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      run_pend_q <= run_pend_d;
    end
  end

endmodule

@@ hw/rtl/gwff_dp.sv @@
`timescale 1ns / 1ps

module gwff_dp #(
  parameter int GRID_SIDE = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [gwff_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [11:0]                     cell_index_i,
  input  logic                            obstacle_i,
  input  gwff_pkg::cmd_t                  cmd_i,
  output gwff_pkg::stat_t                 stat_o,
  output logic                            reply_kind_o,
  output logic [1:0]                      cell_state_o,
  output logic                            run_status_o
);

  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(GRID_SIDE);
  localparam int SW    = $clog2(GRID_SIDE + 1);

  // Configuration
  logic [6:0] grid_side_q;
  logic [5:0] seed_col_q, seed_row_q;

  // Maps, queue and their read registers
  logic [1:0]      cell_mem [DEPTH];
  logic            obs_mem  [DEPTH];
  logic [2*CW-1:0] q_mem    [DEPTH];
  logic [1:0]      cell_rd_q;
  logic            obs_rd_q;
  logic [2*CW-1:0] q_rd_q;

  logic [AW-1:0] clr_cnt_q;
  logic [AW:0]   head_q, tail_q;
  logic [CW-1:0] cur_row_q, cur_col_q, nrow_q, ncol_q;
  logic [1:0]    dc_q, dr_q;
  logic [AW-1:0] ci_q;
  logic          nbr_ok_q, rd_ok_q;

  logic [SW-1:0]    side_use;
  logic [2*SW-1:0]  side_sq;
  logic             read_ok;
  logic [CW:0]      nc_p, nr_p;
  logic [CW-1:0]    nc, nr, mrow, mcol;
  logic             nbr_ok;
  logic [CW+SW-1:0] prod;
  logic [AW-1:0]    ci;
  logic             cw_en;
  logic [AW-1:0]    cw_addr, cr_addr;
  logic [1:0]       cw_data;
  logic             enq;

  // Side in use, clamped to the store
  always_comb begin
    if (32'(grid_side_q) > 32'(GRID_SIDE)) begin
      side_use = SW'(GRID_SIDE);
    end else begin
      side_use = SW'(grid_side_q);
    end
  end

  assign side_sq = (2*SW)'(side_use) * (2*SW)'(side_use);
  assign read_ok = (32'(cell_index_i) < 32'(side_sq)) && (32'(cell_index_i) < DEPTH);

  assign stat_o.seed_out = (32'(seed_col_q) >= 32'(side_use)) ||
                           (32'(seed_row_q) >= 32'(side_use));
  assign stat_o.q_empty  = (head_q == tail_q);
  assign stat_o.nbr_last = (dc_q == 2'd2) && (dr_q == 2'd2);
  assign stat_o.clr_done = (clr_cnt_q == AW'(DEPTH - 1));

  // Neighbor coordinates, offset by one so the test stays unsigned
  assign nc_p   = {1'b0, cur_col_q} + (CW+1)'(dc_q);
  assign nr_p   = {1'b0, cur_row_q} + (CW+1)'(dr_q);
  assign nc     = CW'(nc_p - (CW+1)'(1));
  assign nr     = CW'(nr_p - (CW+1)'(1));
  assign nbr_ok = (nc_p != '0) && (nr_p != '0) &&
                  (32'(nc_p) <= 32'(side_use)) && (32'(nr_p) <= 32'(side_use));

  // Shared raster index: row * side + col
  assign mrow = (cmd_i.op == gwff_pkg::OP_MARK) ? q_rd_q[2*CW-1:CW] : nr;
  assign mcol = (cmd_i.op == gwff_pkg::OP_MARK) ? q_rd_q[CW-1:0]    : nc;
  assign prod = (CW+SW)'(mrow) * (CW+SW)'(side_use);
  assign ci   = AW'(prod + (CW+SW)'(mcol));

  assign enq = (cmd_i.op == gwff_pkg::OP_NDEC) && nbr_ok_q &&
               (cell_rd_q == gwff_pkg::ST_UNKNOWN) && !obs_rd_q;

  // Cell map port select
  always_comb begin
    cw_en   = 1'b0;
    cw_addr = ci;
    cw_data = gwff_pkg::ST_UNKNOWN;
    case (cmd_i.op)
      gwff_pkg::OP_CLR_STEP: begin
        cw_en   = 1'b1;
        cw_addr = clr_cnt_q;
      end
      gwff_pkg::OP_MARK: begin
        cw_en   = 1'b1;
        cw_data = gwff_pkg::ST_FREE;
      end
      gwff_pkg::OP_NDEC: begin
        cw_en   = nbr_ok_q && (cell_rd_q == gwff_pkg::ST_UNKNOWN);
        cw_addr = ci_q;
        cw_data = obs_rd_q ? gwff_pkg::ST_OCCUPIED : gwff_pkg::ST_FRONTIER;
      end
      default: cw_en = 1'b0;
    endcase
  end

  assign cr_addr = (cmd_i.op == gwff_pkg::OP_READ) ? AW'(cell_index_i) : ci;

  // Memories
  always_ff @(posedge clk_i) begin
    if (cw_en) begin
      cell_mem[cw_addr] <= cw_data;
    end
    if ((cmd_i.op == gwff_pkg::OP_LOAD) && (32'(cell_index_i) < DEPTH)) begin
      obs_mem[AW'(cell_index_i)] <= obstacle_i;
    end
    if (cmd_i.op == gwff_pkg::OP_SEED) begin
      q_mem[tail_q[AW-1:0]] <= {CW'(seed_row_q), CW'(seed_col_q)};
    end else if (enq) begin
      q_mem[tail_q[AW-1:0]] <= {nrow_q, ncol_q};
    end
    cell_rd_q <= cell_mem[cr_addr];
    obs_rd_q  <= obs_mem[ci];
    q_rd_q    <= q_mem[head_q[AW-1:0]];
  end

  // Control counters and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= gwff_pkg::GRID_SIDE_RST;
      seed_col_q  <= gwff_pkg::SEED_COL_RST;
      seed_row_q  <= gwff_pkg::SEED_ROW_RST;
      clr_cnt_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      dc_q        <= '0;
      dr_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gwff_pkg::CFG_GRID_SIDE: grid_side_q <= cfg_data_i;
          gwff_pkg::CFG_SEED_COL:  seed_col_q  <= cfg_data_i[5:0];
          gwff_pkg::CFG_SEED_ROW:  seed_row_q  <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        gwff_pkg::OP_CLR_START: begin
          clr_cnt_q <= '0;
          head_q    <= '0;
          tail_q    <= '0;
        end
        gwff_pkg::OP_CLR_STEP: clr_cnt_q <= clr_cnt_q + AW'(1);
        gwff_pkg::OP_SEED:     tail_q    <= tail_q + (AW+1)'(1);
        gwff_pkg::OP_POP:      head_q    <= head_q + (AW+1)'(1);
        gwff_pkg::OP_MARK: begin
          dc_q <= '0;
          dr_q <= '0;
        end
        gwff_pkg::OP_NDEC: begin
          if (enq) begin
            tail_q <= tail_q + (AW+1)'(1);
          end
          if (dr_q == 2'd2) begin
            dr_q <= '0;
            dc_q <= dc_q + 2'd1;
          end else begin
            dr_q <= dr_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      gwff_pkg::OP_MARK: begin
        cur_row_q <= q_rd_q[2*CW-1:CW];
        cur_col_q <= q_rd_q[CW-1:0];
      end
      gwff_pkg::OP_NRD: begin
        ci_q     <= ci;
        nbr_ok_q <= nbr_ok;
        nrow_q   <= nr;
        ncol_q   <= nc;
      end
      gwff_pkg::OP_READ: rd_ok_q <= read_ok;
      gwff_pkg::OP_CAP_RUN: begin
        reply_kind_o <= 1'b0;
        cell_state_o <= gwff_pkg::ST_UNKNOWN;
        run_status_o <= stat_o.seed_out;
      end
      gwff_pkg::OP_CAP_READ: begin
        reply_kind_o <= 1'b1;
        run_status_o <= 1'b0;
        if (!rd_ok_q) begin
          cell_state_o <= gwff_pkg::ST_UNKNOWN;
        end else if (cell_rd_q == gwff_pkg::ST_FRONTIER) begin
          cell_state_o <= gwff_pkg::ST_FREE;
        end else begin
          cell_state_o <= cell_rd_q;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/grid_wavefront_flood_fill_top.sv @@
`timescale 1ns / 1ps
// Load request: taken while idle, no reply. Read request: the cell is registered, then
// captured into the reply registers, then shown. Run request: a clearing pass over all
// GRID_SIDE*GRID_SIDE cells of the cell map; if the seed is in the grid, then a pop,
// a mark, and a read and a decide step per neighbor of each cell reached; then the reply.
// One request is in flight at a time. Reset: the same clearing pass; no request taken.
module grid_wavefront_flood_fill_top #(
  parameter int GRID_SIDE = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gwff_in_if.sink                         in_ch,
  gwff_out_if.source                      out_ch,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [gwff_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  gwff_pkg::cmd_t  cmd;
  gwff_pkg::stat_t stat;

  // Sequencer
  gwff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_func_i   (in_ch.func),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Maps, queue and reply registers
  gwff_dp #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cell_index_i (in_ch.cell_index),
    .obstacle_i   (in_ch.obstacle),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .reply_kind_o (out_ch.reply_kind),
    .cell_state_o (out_ch.cell_state),
    .run_status_o (out_ch.run_status)
  );

endmodule

@@ hw/rtl/gwff_checker.sv @@
`timescale 1ns / 1ps

module gwff_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic       out_ready,
  input logic       reply_kind,
  input logic [1:0] cell_state,
  input logic       run_status
);

  // A held reply keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(reply_kind) &&
    $stable(cell_state) && $stable(run_status))
    else $error("reply dropped or changed while stalled");

  // One request in flight: no intake while a reply waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid))
    else $error("ready while reply pending");

  // Read replies never show the frontier code; run fields are fixed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && reply_kind |-> cell_state != gwff_pkg::ST_FRONTIER && !run_status)
    else $error("bad read reply");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !reply_kind |-> cell_state == gwff_pkg::ST_UNKNOWN)
    else $error("bad run reply");

  // A run request starts the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_func == gwff_pkg::FUNC_RUN |=> !in_ready && !out_valid)
    else $error("run did not start");

endmodule

bind grid_wavefront_flood_fill_top gwff_checker u_gwff_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_func    (in_ch.func),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .reply_kind (out_ch.reply_kind),
  .cell_state (out_ch.cell_state),
  .run_status (out_ch.run_status)
);

@@ dv/grid_wavefront_flood_fill_top_tb.sv @@
`timescale 1ns / 1ps

module grid_wavefront_flood_fill_top_tb;

  localparam int SIDE_MAX = 64;
  localparam int DEPTH = SIDE_MAX * SIDE_MAX;
  localparam logic [1:0] FUNC_BAD = 2'd3;

  typedef struct packed {
    logic       reply_kind;
    logic [1:0] cell_state;
    logic       run_status;
  } reply_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] cell_index;
    logic        obstacle;
    logic        check_fixed;
    reply_t      fixed;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = gwff_pkg::CFG_GRID_SIDE;
  logic [6:0] cfg_data_i = '0;

  gwff_in_if  in_ch ();
  gwff_out_if out_ch ();

  grid_wavefront_flood_fill_top #(.GRID_SIDE(SIDE_MAX)) u_top (
    .clk_i, .rst_ni, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Predictor state
  logic [6:0]  side_q = gwff_pkg::GRID_SIDE_RST;
  logic [5:0]  seed_col_q = gwff_pkg::SEED_COL_RST;
  logic [5:0]  seed_row_q = gwff_pkg::SEED_ROW_RST;
  logic        obst_map [DEPTH];
  logic [1:0]  cell_map [DEPTH];
  int          wave_q [$];
  reply_t      replies_due [$];
  row_t        fixed_due [$];

  int errors = 0;
  int n_reqs = 0;
  int n_replies = 0;
  int n_runs = 0;
  int send_idle = 27;
  int recv_idle = 48;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Timeout waiting for replies");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Breadth-first fill from the seed; returns the run status
  function automatic logic flood_map();
    int s, idx, r, c, nr, nc, ci, head;
    s = (side_q > SIDE_MAX) ? SIDE_MAX : side_q;
    foreach (cell_map[i]) cell_map[i] = gwff_pkg::ST_UNKNOWN;
    if (seed_col_q >= s || seed_row_q >= s) return 1'b1;
    wave_q.delete();
    wave_q.insert(wave_q.size(), seed_row_q * s + seed_col_q);
    head = 0;
    while (head < wave_q.size()) begin
      idx = wave_q[head];
      head++;
      r = idx / s;
      c = idx % s;
      cell_map[idx] = gwff_pkg::ST_FREE;
      for (int dc = -1; dc <= 1; dc++) begin
        for (int dr = -1; dr <= 1; dr++) begin
          nc = c + dc;
          nr = r + dr;
          if (nc < 0 || nr < 0 || nc >= s || nr >= s) continue;
          ci = nr * s + nc;
          if (cell_map[ci] != gwff_pkg::ST_UNKNOWN) continue;
          if (obst_map[ci]) begin
            cell_map[ci] = gwff_pkg::ST_OCCUPIED;
          end else begin
            wave_q.insert(wave_q.size(), ci);
            cell_map[ci] = gwff_pkg::ST_FRONTIER;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // Expected reply of one accepted request
  task automatic predict_request(input logic [1:0] f, input logic [11:0] ci, input logic ob);
    reply_t rp;
    int s;
    rp = '0;
    s = (side_q > SIDE_MAX) ? SIDE_MAX : side_q;
    case (f)
      gwff_pkg::FUNC_LOAD: obst_map[ci] = ob;
      gwff_pkg::FUNC_RUN: begin
        rp.run_status = flood_map();
        replies_due.insert(replies_due.size(), rp);
        n_runs++;
      end
      gwff_pkg::FUNC_READ: begin
        rp.reply_kind = 1'b1;
        if (ci < s * s) begin
          rp.cell_state = (cell_map[ci] == gwff_pkg::ST_FRONTIER) ? gwff_pkg::ST_FREE
                                                                   : cell_map[ci];
        end
        replies_due.insert(replies_due.size(), rp);
      end
      default: ;
    endcase
  endtask

  // Request driver; valid stays up for a request that follows without a gap
  task automatic send_req(input logic [1:0] f, input logic [11:0] ci, input logic ob);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.cell_index <= ci;
    in_ch.obstacle <= ob;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_request(f, ci, ob);
    n_reqs++;
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [6:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      gwff_pkg::CFG_GRID_SIDE: side_q = val;
      gwff_pkg::CFG_SEED_COL:  seed_col_q = val[5:0];
      default:                 seed_row_q = val[5:0];
    endcase
    @(posedge clk_i);
  endtask

  // Drop valid, wait until all replies are in, then a short margin
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Load every cell of the grid in use so no run sees an unwritten bit
  task automatic load_region(input int pct);
    int s;
    s = (side_q > SIDE_MAX) ? SIDE_MAX : side_q;
    for (int i = 0; i < s * s; i++) begin
      send_req(gwff_pkg::FUNC_LOAD, 12'(i), 1'($urandom_range(99) < pct));
    end
  endtask

  // Reply monitor and checker
  initial begin
    reply_t got, want;
    row_t fx;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.reply_kind, out_ch.cell_state, out_ch.run_status};
        n_replies++;
        if (replies_due.size() == 0) begin
          $error("unexpected reply %p", got);
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (fixed_due.size() != 0) begin
            fx = fixed_due.pop_front();
            if (fx.check_fixed) want = fx.fixed;
          end
          if (got.reply_kind != want.reply_kind) begin
            $error("reply_kind exp %0d got %0d", want.reply_kind, got.reply_kind);
            errors++;
          end
          if (got.cell_state != want.cell_state) begin
            $error("cell_state exp %0d got %0d", want.cell_state, got.cell_state);
            errors++;
          end
          if (got.run_status != want.run_status) begin
            $error("run_status exp %0d got %0d", want.run_status, got.run_status);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Directed rows; fixed reply typed in where obvious
  row_t dir_rows [$];

  task automatic add_row(input logic [1:0] f, input logic [11:0] ci, input logic ob,
                         input logic chk, input reply_t rp);
    dir_rows.insert(dir_rows.size(), row_t'{f, ci, ob, chk, rp});
  endtask

  task automatic walk_rows();
    foreach (dir_rows[i]) begin
      if (dir_rows[i].func == gwff_pkg::FUNC_RUN || dir_rows[i].func == gwff_pkg::FUNC_READ)
        fixed_due.insert(fixed_due.size(), dir_rows[i]);
      send_req(dir_rows[i].func, dir_rows[i].cell_index, dir_rows[i].obstacle);
    end
    dir_rows.delete();
  endtask

  task automatic random_reqs(input int n);
    int k;
    logic [1:0] f;
    logic [11:0] ci;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      f = (k < 8) ? gwff_pkg::FUNC_RUN : (k < 25) ? gwff_pkg::FUNC_LOAD :
          (k < 30) ? FUNC_BAD : gwff_pkg::FUNC_READ;
      ci = ($urandom_range(4) == 0) ? 12'($urandom) :
           12'($urandom_range(int'(side_q) * int'(side_q) + 2));
      send_req(f, ci, 1'($urandom_range(1)));
      if (f == gwff_pkg::FUNC_RUN) drain();
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = gwff_pkg::FUNC_LOAD;
    in_ch.cell_index = '0;
    in_ch.obstacle = 1'b0;
    foreach (cell_map[i]) cell_map[i] = gwff_pkg::ST_UNKNOWN;
    foreach (obst_map[i]) obst_map[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset the map is unknown everywhere
    add_row(gwff_pkg::FUNC_READ, 12'd0, 1'b0, 1'b1, '{1'b1, gwff_pkg::ST_UNKNOWN, 1'b0});
    add_row(gwff_pkg::FUNC_READ, 12'd4095, 1'b0, 1'b1, '{1'b1, gwff_pkg::ST_UNKNOWN, 1'b0});
    add_row(FUNC_BAD, 12'd5, 1'b1, 1'b0, '0);
    walk_rows();
    drain();

    // Pocket around the seed: walls on all sides but one free cell, itself walled in
    add_row(gwff_pkg::FUNC_LOAD, 12'd2015, 1'b1, 1'b0, '0);
    add_row(gwff_pkg::FUNC_LOAD, 12'd2016, 1'b1, 1'b0, '0);
    add_row(gwff_pkg::FUNC_LOAD, 12'd2017, 1'b1, 1'b0, '0);
    add_row(gwff_pkg::FUNC_LOAD, 12'd2079, 1'b1, 1'b0, '0);
    add_row(gwff_pkg::FUNC_LOAD, 12'd2081, 1'b0, 1'b0, '0);
    add_row(gwff_pkg::FUNC_LOAD, 12'd2143, 1'b1, 1'b0, '0);
    add_row(gwff_pkg::FUNC_LOAD, 12'd2144, 1'b1, 1'b0, '0);
    add_row(gwff_pkg::FUNC_LOAD, 12'd2145, 1'b1, 1'b0, '0);
    add_row(gwff_pkg::FUNC_LOAD, 12'd2018, 1'b1, 1'b0, '0);
    add_row(gwff_pkg::FUNC_LOAD, 12'd2082, 1'b1, 1'b0, '0);
    add_row(gwff_pkg::FUNC_LOAD, 12'd2146, 1'b1, 1'b0, '0);
    add_row(gwff_pkg::FUNC_RUN, 12'd0, 1'b0, 1'b1, '{1'b0, gwff_pkg::ST_UNKNOWN, 1'b0});
    add_row(gwff_pkg::FUNC_READ, 12'd2080, 1'b0, 1'b1, '{1'b1, gwff_pkg::ST_FREE, 1'b0});
    add_row(gwff_pkg::FUNC_READ, 12'd2081, 1'b0, 1'b0, '0);
    add_row(gwff_pkg::FUNC_READ, 12'd2079, 1'b0, 1'b1, '{1'b1, gwff_pkg::ST_OCCUPIED, 1'b0});
    add_row(gwff_pkg::FUNC_READ, 12'd2018, 1'b0, 1'b0, '0);
    add_row(gwff_pkg::FUNC_READ, 12'd0, 1'b0, 1'b1, '{1'b1, gwff_pkg::ST_UNKNOWN, 1'b0});
    add_row(gwff_pkg::FUNC_READ, 12'd4095, 1'b0, 1'b0, '0);
    add_row(FUNC_BAD, 12'd0, 1'b0, 1'b0, '0);
    walk_rows();
    drain();

    // Side above the store limit acts as full size; corner seed walled in
    write_cfg(gwff_pkg::CFG_GRID_SIDE, 7'd127);
    write_cfg(gwff_pkg::CFG_SEED_COL, 7'd63);
    write_cfg(gwff_pkg::CFG_SEED_ROW, 7'd0);
    add_row(gwff_pkg::FUNC_LOAD, 12'd62, 1'b1, 1'b0, '0);
    add_row(gwff_pkg::FUNC_LOAD, 12'd126, 1'b1, 1'b0, '0);
    add_row(gwff_pkg::FUNC_LOAD, 12'd127, 1'b1, 1'b0, '0);
    add_row(gwff_pkg::FUNC_RUN, 12'd0, 1'b0, 1'b1, '{1'b0, gwff_pkg::ST_UNKNOWN, 1'b0});
    add_row(gwff_pkg::FUNC_READ, 12'd63, 1'b0, 1'b1, '{1'b1, gwff_pkg::ST_FREE, 1'b0});
    add_row(gwff_pkg::FUNC_READ, 12'd62, 1'b0, 1'b1, '{1'b1, gwff_pkg::ST_OCCUPIED, 1'b0});
    add_row(gwff_pkg::FUNC_READ, 12'd4032, 1'b0, 1'b0, '0);
    walk_rows();
    drain();

    // Seed outside the grid clears the map and reports an error
    write_cfg(gwff_pkg::CFG_GRID_SIDE, 7'd8);
    add_row(gwff_pkg::FUNC_RUN, 12'd0, 1'b0, 1'b1, '{1'b0, gwff_pkg::ST_UNKNOWN, 1'b1});
    add_row(gwff_pkg::FUNC_READ, 12'd63, 1'b0, 1'b1, '{1'b1, gwff_pkg::ST_UNKNOWN, 1'b0});
    add_row(gwff_pkg::FUNC_READ, 12'd64, 1'b0, 1'b1, '{1'b1, gwff_pkg::ST_UNKNOWN, 1'b0});
    walk_rows();
    drain();

    // Side zero: always outside, reads unknown
    write_cfg(gwff_pkg::CFG_GRID_SIDE, 7'd0);
    add_row(gwff_pkg::FUNC_RUN, 12'd0, 1'b0, 1'b1, '{1'b0, gwff_pkg::ST_UNKNOWN, 1'b1});
    add_row(gwff_pkg::FUNC_READ, 12'd0, 1'b0, 1'b1, '{1'b1, gwff_pkg::ST_UNKNOWN, 1'b0});
    walk_rows();
    drain();

    // Side one: the single cell is the seed
    write_cfg(gwff_pkg::CFG_GRID_SIDE, 7'd1);
    write_cfg(gwff_pkg::CFG_SEED_COL, 7'd0);
    add_row(gwff_pkg::FUNC_RUN, 12'd0, 1'b0, 1'b1, '{1'b0, gwff_pkg::ST_UNKNOWN, 1'b0});
    add_row(gwff_pkg::FUNC_READ, 12'd0, 1'b0, 1'b1, '{1'b1, gwff_pkg::ST_FREE, 1'b0});
    add_row(gwff_pkg::FUNC_READ, 12'd1, 1'b0, 1'b1, '{1'b1, gwff_pkg::ST_UNKNOWN, 1'b0});
    walk_rows();
    drain();

    // Random phases over small grids with different idling
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 27 : (ph == 1) ? 48 : 0;
      recv_idle = (ph == 0) ? 48 : (ph == 1) ? 27 : 0;
      write_cfg(gwff_pkg::CFG_GRID_SIDE, 7'($urandom_range(2, 4)));
      write_cfg(gwff_pkg::CFG_SEED_COL, 7'($urandom_range(int'(side_q))));
      write_cfg(gwff_pkg::CFG_SEED_ROW, 7'($urandom_range(int'(side_q) - 1)));
      load_region(ph == 2 ? 50 : 15);
      drain();
      random_reqs(16);
      drain();
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("Sent %0d requests, %0d flood runs; checked %0d replies", n_reqs, n_runs,
             n_replies);
    $display("Grid sides 0, 1, 8, 2 to 4 random, and above the store limit");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/gwff_pkg.sv
hw/rtl/gwff_if.sv
hw/rtl/gwff_ctrl.sv
hw/rtl/gwff_dp.sv
hw/rtl/grid_wavefront_flood_fill_top.sv
hw/rtl/gwff_checker.sv
dv/grid_wavefront_flood_fill_top_tb.sv
